>>> rtl/mf_pkg.sv
// ----------------------------------------------------------------------------
// mf_pkg
// Shared widths, register codes, reset values and types of the 9x9 rank filter.
// ----------------------------------------------------------------------------
package mf_pkg;

  localparam int unsigned MAX_ROW_SAMPLES_DEF = 8192;
  localparam int unsigned HALF_WINDOW_DEF     = 4;

  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned WIDTH_W   = 12;
  localparam int unsigned HEIGHT_W  = 13;
  localparam int unsigned COMP_W    = 3;
  localparam int unsigned RANK_W    = 7;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned POS_W     = 27;
  localparam int unsigned ROW_W     = 14;
  localparam int unsigned LEN_W     = 15;
  localparam int unsigned COMP_MAX  = 4;
  localparam int unsigned OUTQ_DEPTH = 16;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [COMP_W-1:0]   COMP_RST   = 3'd3;
  localparam logic [RANK_W-1:0]   RANK_RST   = 7'd40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_COMPONENTS   = 2'd2,
    REG_SELECT_RANK  = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_FLUSH  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic [COMP_W-1:0]   comp;
    logic [RANK_W-1:0]   rank;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                last;
  } res_t;

endpackage

>>> rtl/mf_ram.sv
// ----------------------------------------------------------------------------
// mf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/mf_front.sv
// ----------------------------------------------------------------------------
// mf_front
// Frame counters, line store (one column of past rows per entry), column
// shift line and border masking; delivers one registered window per centre.
// ----------------------------------------------------------------------------
module mf_front import mf_pkg::*; #(
  parameter int unsigned MaxRowSamples = MAX_ROW_SAMPLES_DEF,
  parameter int unsigned HalfWindow    = HALF_WINDOW_DEF,
  localparam int unsigned Rows = 2 * HalfWindow + 1,
  localparam int unsigned NWin = Rows * Rows
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cfg_t                               cfg_i,
  input  logic                               in_acc_i,
  input  logic                               command_i,
  input  logic [SAMPLE_W-1:0]                sample_i,
  output logic                               res_o,
  output logic                               win_valid_o,
  output logic [NWin-1:0][SAMPLE_W-1:0]      win_o,
  output logic                               win_last_o,
  output logic [RANK_W-1:0]                  win_rank_o
);

  localparam int unsigned Span  = 2 * HalfWindow;
  localparam int unsigned MemW  = SAMPLE_W * Span;
  localparam int unsigned AddrW = $clog2(MaxRowSamples);
  localparam int unsigned TapD  = Span * COMP_MAX;
  localparam int unsigned XW    = LEN_W + 1;
  localparam int unsigned YW    = ROW_W + 1;

  typedef logic [Rows-1:0][SAMPLE_W-1:0] vec_t;

  // geometry
  logic [WIDTH_W-1:0]  wid;
  logic [HEIGHT_W-1:0] hgt;
  logic [COMP_W-1:0]   comp;
  logic [LEN_W-1:0]    len_full, len;
  logic [POS_W-1:0]    lag;
  logic [RANK_W-1:0]   rank_clamp;

  always_comb begin
    wid  = (cfg_i.width == '0) ? WIDTH_W'(1) : cfg_i.width;
    hgt  = (cfg_i.height == '0) ? HEIGHT_W'(1) : cfg_i.height;
    if (cfg_i.comp == '0) begin
      comp = COMP_W'(1);
    end else if (cfg_i.comp > COMP_W'(COMP_MAX)) begin
      comp = COMP_W'(COMP_MAX);
    end else begin
      comp = cfg_i.comp;
    end
    len_full = LEN_W'(wid) * LEN_W'(comp);
    len      = (len_full > LEN_W'(MaxRowSamples)) ? LEN_W'(MaxRowSamples) : len_full;
    lag      = POS_W'(HalfWindow) * POS_W'(len) + POS_W'(HalfWindow) * POS_W'(comp);
    rank_clamp = (cfg_i.rank > RANK_W'(NWin - 1)) ? RANK_W'(NWin - 1) : cfg_i.rank;
  end

  // position counters
  logic [POS_W-1:0] p_q, p_d;
  logic [AddrW-1:0] xi_q, xi_d;
  logic [ROW_W-1:0] yi_q, yi_d;
  logic [LEN_W-1:0] xc_q, xc_d;
  logic [ROW_W-1:0] yc_q, yc_d;

  logic in_frame, ignore, go, has_res, last;

  assign in_frame = yi_q < ROW_W'(hgt);
  assign ignore   = in_frame && (command_i == CMD_FLUSH);
  assign go       = in_acc_i && !ignore;
  assign has_res  = p_q >= lag;
  assign last     = (yc_q >= ROW_W'(hgt)) ||
                    ((yc_q == ROW_W'(hgt) - ROW_W'(1)) && (xc_q >= len - LEN_W'(1)));
  assign res_o    = go && has_res;

  always_comb begin
    p_d  = p_q;
    xi_d = xi_q;
    yi_d = yi_q;
    xc_d = xc_q;
    yc_d = yc_q;
    if (go) begin
      if (has_res && last) begin
        p_d  = '0;
        xi_d = '0;
        yi_d = '0;
        xc_d = '0;
        yc_d = '0;
      end else begin
        p_d = p_q + POS_W'(1);
        if (LEN_W'(xi_q) + LEN_W'(1) >= len) begin
          xi_d = '0;
          yi_d = yi_q + ROW_W'(1);
        end else begin
          xi_d = xi_q + AddrW'(1);
        end
        if (has_res) begin
          if (xc_q + LEN_W'(1) >= len) begin
            xc_d = '0;
            yc_d = yc_q + ROW_W'(1);
          end else begin
            xc_d = xc_q + LEN_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q  <= '0;
      xi_q <= '0;
      yi_q <= '0;
      xc_q <= '0;
      yc_q <= '0;
    end else begin
      p_q  <= p_d;
      xi_q <= xi_d;
      yi_q <= yi_d;
      xc_q <= xc_d;
      yc_q <= yc_d;
    end
  end

  // border masks for the centre of this word
  logic [YW-1:0]   yh;
  logic [XW-1:0]   xh;
  logic [Rows-1:0] row_ok, col_ok;

  always_comb begin
    logic [XW-1:0] bc;
    yh = YW'(yc_q) + YW'(HalfWindow);
    xh = XW'(xc_q) + XW'(HalfWindow) * XW'(comp);
    for (int a = 0; a < Rows; a++) begin
      row_ok[a] = (yh >= YW'(a)) && ((yh - YW'(a)) < YW'(hgt));
    end
    for (int b = 0; b < Rows; b++) begin
      bc = XW'(b) * XW'(comp);
      col_ok[b] = (xh >= bc) && ((xh - bc) < XW'(len));
    end
  end

  // stage 1: line store read returns
  logic                s1_valid_q;
  logic                s1_res_q, s1_last_q, fwd_q;
  logic [RANK_W-1:0]   s1_rank_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic [AddrW-1:0]    s1_addr_q;
  logic [Rows-1:0]     s1_row_ok_q, s1_col_ok_q;
  logic [COMP_W-1:0]   s1_comp_q;
  logic [MemW-1:0]     fwd_data_q;
  logic [MemW-1:0]     ram_rd, old, wr_data;
  vec_t                newvec;

  mf_ram #(
    .Width(MemW),
    .Depth(MaxRowSamples)
  ) u_line_ram (
    .clk_i     (clk_i),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (wr_data),
    .rd_en_i   (go),
    .rd_addr_i (xi_q),
    .rd_data_o (ram_rd)
  );

  // same entry written as it is read: take the write data
  assign old     = fwd_q ? fwd_data_q : ram_rd;
  assign newvec  = vec_t'({old, s1_sample_q});
  assign wr_data = {old[MemW-SAMPLE_W-1:0], s1_sample_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      s1_res_q    <= has_res;
      s1_last_q   <= last;
      s1_rank_q   <= rank_clamp;
      s1_sample_q <= sample_i;
      s1_addr_q   <= xi_q;
      s1_row_ok_q <= row_ok;
      s1_col_ok_q <= col_ok;
      s1_comp_q   <= comp;
      fwd_q       <= s1_valid_q && (s1_addr_q == xi_q);
      fwd_data_q  <= wr_data;
    end
  end

  // column shift line
  vec_t tap_q [TapD];

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      tap_q[0] <= newvec;
      for (int i = 1; i < TapD; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  vec_t colv [Rows];

  assign colv[0] = newvec;

  for (genvar b = 1; b < Rows; b++) begin : g_tap
    always_comb begin
      case (s1_comp_q)
        3'd1:    colv[b] = tap_q[b-1];
        3'd2:    colv[b] = tap_q[2*b-1];
        3'd3:    colv[b] = tap_q[3*b-1];
        default: colv[b] = tap_q[4*b-1];
      endcase
    end
  end

  // stage 2: masked window
  logic [NWin-1:0][SAMPLE_W-1:0] win_d, win_q;
  logic                          win_valid_q, win_last_q;
  logic [RANK_W-1:0]             win_rank_q;

  always_comb begin
    for (int b = 0; b < Rows; b++) begin
      for (int a = 0; a < Rows; a++) begin
        win_d[b*Rows+a] = (s1_row_ok_q[a] && s1_col_ok_q[b]) ? colv[b][a] : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_valid_q <= 1'b0;
    end else begin
      win_valid_q <= s1_valid_q && s1_res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      win_q      <= win_d;
      win_last_q <= s1_last_q;
      win_rank_q <= s1_rank_q;
    end
  end

  assign win_valid_o = win_valid_q;
  assign win_o       = win_q;
  assign win_last_o  = win_last_q;
  assign win_rank_o  = win_rank_q;

endmodule

>>> rtl/mf_rank.sv
// ----------------------------------------------------------------------------
// mf_rank
// Radix rank select: one pipeline stage per sample bit, MSB first, each
// counting the live window values that have a zero in that bit.
// ----------------------------------------------------------------------------
module mf_rank import mf_pkg::*; #(
  parameter int unsigned HalfWindow = HALF_WINDOW_DEF,
  localparam int unsigned Rows = 2 * HalfWindow + 1,
  localparam int unsigned NWin = Rows * Rows
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [NWin-1:0][SAMPLE_W-1:0] win_i,
  input  logic                          last_i,
  input  logic [RANK_W-1:0]             rank_i,
  output logic                          valid_o,
  output logic [SAMPLE_W-1:0]           value_o,
  output logic                          last_o
);

  localparam int unsigned CntW = $clog2(NWin + 1);
  localparam int unsigned CmpW = (RANK_W > CntW) ? RANK_W : CntW;

  logic                          st_valid [SAMPLE_W+1];
  logic                          st_last  [SAMPLE_W+1];
  logic [SAMPLE_W-1:0]           st_value [SAMPLE_W+1];
  logic [NWin-1:0][SAMPLE_W-1:0] st_win   [SAMPLE_W];
  logic [NWin-1:0]               st_alive [SAMPLE_W];
  logic [RANK_W-1:0]             st_rank  [SAMPLE_W];

  assign st_valid[0] = valid_i;
  assign st_last[0]  = last_i;
  assign st_value[0] = '0;
  assign st_win[0]   = win_i;
  assign st_alive[0] = '1;
  assign st_rank[0]  = rank_i;

  for (genvar k = 0; k < SAMPLE_W; k++) begin : g_stage
    localparam int unsigned Bit = SAMPLE_W - 1 - k;

    logic [NWin-1:0]     zeros, alive_n;
    logic [CntW-1:0]     cnt;
    logic                one;
    logic [RANK_W-1:0]   rank_n;
    logic [SAMPLE_W-1:0] value_n;

    always_comb begin
      for (int e = 0; e < NWin; e++) begin
        zeros[e] = st_alive[k][e] & ~st_win[k][e][Bit];
      end
      cnt = CntW'($countones(zeros));
      one = !(CmpW'(st_rank[k]) < CmpW'(cnt));
      for (int e = 0; e < NWin; e++) begin
        alive_n[e] = st_alive[k][e] & (st_win[k][e][Bit] == one);
      end
      rank_n       = one ? st_rank[k] - RANK_W'(cnt) : st_rank[k];
      value_n      = st_value[k];
      value_n[Bit] = one;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_valid[k+1] <= 1'b0;
      end else begin
        st_valid[k+1] <= st_valid[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (st_valid[k]) begin
        st_last[k+1]  <= st_last[k];
        st_value[k+1] <= value_n;
      end
    end

    if (k < SAMPLE_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (st_valid[k]) begin
          st_win[k+1]   <= st_win[k];
          st_alive[k+1] <= alive_n;
          st_rank[k+1]  <= rank_n;
        end
      end
    end
  end

  assign valid_o = st_valid[SAMPLE_W];
  assign value_o = st_value[SAMPLE_W];
  assign last_o  = st_last[SAMPLE_W];

endmodule

>>> rtl/mf_outq.sv
// ----------------------------------------------------------------------------
// mf_outq
// Output queue with credit count; a credit is taken for every word that
// will give a result, so the pipeline never has to stop.
// ----------------------------------------------------------------------------
module mf_outq import mf_pkg::*; #(
  parameter int unsigned Depth = OUTQ_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic                push_i,
  input  logic [SAMPLE_W-1:0] push_value_i,
  input  logic                push_last_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SAMPLE_W-1:0] filtered_o,
  output logic                frame_last_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t            entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, credit_q;
  logic            pop;

  assign out_valid_o  = count_q != '0;
  assign pop          = out_valid_o && !out_stall_i;
  assign full_o       = credit_q == CntW'(Depth);
  assign filtered_o   = entry_q[rd_ptr_q].value;
  assign frame_last_o = entry_q[rd_ptr_q].last;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= '{value: push_value_i, last: push_last_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      credit_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      count_q  <= count_q + CntW'(push_i) - CntW'(pop);
      credit_q <= credit_q + CntW'(take_i) - CntW'(pop);
    end
  end

endmodule

>>> rtl/median_filter_9x9.sv
// ----------------------------------------------------------------------------
// median_filter_9x9
// Streaming rank-order filter over a 9x9 window of interleaved image samples.
// ----------------------------------------------------------------------------
// Input words carry one colour component sample in raster order, or a flush
// step after the last sample of a frame. A flush inside the frame is dropped.
// Output words carry the selected-rank value of the window centred four rows
// and four pixels behind the input, zero outside the image, and frame_last on
// the final centre; the block then starts a new frame.
// Throughput is one word per cycle while in_stall_o is low. A result passes
// the line store read stage, the window register, the eight radix stages of
// the rank select and the queue write before it is offered.
// Outputs collect in a 16-word queue; in_stall_o rises only when every slot is
// booked, so a stalled receiver holds the input after the queue fills.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while idle;
// the block does not enforce this, so the user must keep to it. Reset restores
// 640x480, three components, rank 40, and empties the pipeline; the line store
// needs no clearing as rows above the frame are masked.
// ----------------------------------------------------------------------------
module median_filter_9x9 import mf_pkg::*; #(
  parameter int unsigned MaxRowSamples = MAX_ROW_SAMPLES_DEF,
  parameter int unsigned HalfWindow    = HALF_WINDOW_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 command_i,
  input  logic [SAMPLE_W-1:0]  sample_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SAMPLE_W-1:0]  filtered_o,
  output logic                 frame_last_o
);

  localparam int unsigned Rows = 2 * HalfWindow + 1;
  localparam int unsigned NWin = Rows * Rows;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{width: WIDTH_RST, height: HEIGHT_RST, comp: COMP_RST, rank: RANK_RST};
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  cfg_q.width  <= cfg_data_i[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: cfg_q.height <= cfg_data_i[HEIGHT_W-1:0];
        REG_COMPONENTS:   cfg_q.comp   <= cfg_data_i[COMP_W-1:0];
        REG_SELECT_RANK:  cfg_q.rank   <= cfg_data_i[RANK_W-1:0];
        default:          cfg_q        <= cfg_q;
      endcase
    end
  end

  logic                          in_acc, res_take;
  logic                          win_valid, win_last;
  logic [NWin-1:0][SAMPLE_W-1:0] win;
  logic [RANK_W-1:0]             win_rank;
  logic                          rk_valid, rk_last, full;
  logic [SAMPLE_W-1:0]           rk_value;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = full;

  mf_front #(
    .MaxRowSamples(MaxRowSamples),
    .HalfWindow   (HalfWindow)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_acc_i    (in_acc),
    .command_i   (command_i),
    .sample_i    (sample_i),
    .res_o       (res_take),
    .win_valid_o (win_valid),
    .win_o       (win),
    .win_last_o  (win_last),
    .win_rank_o  (win_rank)
  );

  mf_rank #(
    .HalfWindow(HalfWindow)
  ) u_rank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (win_valid),
    .win_i   (win),
    .last_i  (win_last),
    .rank_i  (win_rank),
    .valid_o (rk_valid),
    .value_o (rk_value),
    .last_o  (rk_last)
  );

  mf_outq #(
    .Depth(OUTQ_DEPTH)
  ) u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (res_take),
    .push_i       (rk_valid),
    .push_value_i (rk_value),
    .push_last_i  (rk_last),
    .full_o       (full),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .filtered_o   (filtered_o),
    .frame_last_o (frame_last_o)
  );

endmodule
